// ===== rtl/core/mvp_pkg.sv =====
// shared types, constants and helpers for the winch motor velocity controller
// no dependencies
package mvp_pkg;

  localparam int TICK_HZ_DEF        = 1000;
  localparam int HALT_TICKS_DEF     = 250;
  localparam int WATCHDOG_TICKS_DEF = 2;

  // serial multiplier: 48-bit magnitude times 32-bit magnitude
  localparam int MA_W  = 48;
  localparam int MB_W  = 32;
  localparam int P_W   = MA_W + MB_W;
  localparam int DIV_W = 32;

  localparam int TERM_W = 42;
  localparam int ACC_W  = 44;

  localparam logic [P_W-17:0] TERM_LIM = (P_W-16)'(64'd1 << 40);
  localparam logic signed [31:0] SMALL_VEL = 32'sd65;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FORCE = 2'd1,
    REQ_CMD   = 2'd2,
    REQ_NONE  = 2'd3
  } mvp_req_t;

  typedef enum logic [2:0] {
    REG_FORCE_UP  = 3'd0,
    REG_FORCE_LO  = 3'd1,
    REG_ACCEL     = 3'd2,
    REG_GAIN_P    = 3'd3,
    REG_GAIN_I    = 3'd4,
    REG_GAIN_D    = 3'd5,
    REG_FILT_COEF = 3'd6,
    REG_PWM_PER   = 3'd7
  } mvp_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILT_GO,
    ST_FILT_WAIT,
    ST_VEL_GO,
    ST_VEL_WAIT,
    ST_HALT,
    ST_RATE_WAIT,
    ST_RAMP,
    ST_ERR,
    ST_PROP,
    ST_PROP_WAIT,
    ST_DMUL,
    ST_DMUL_WAIT,
    ST_INTEG,
    ST_INTEG_WAIT,
    ST_DERIV,
    ST_DERIV_WAIT,
    ST_CLAMP,
    ST_COUNT,
    ST_COUNT_WAIT,
    ST_OUT
  } mvp_state_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mvp_mul_req_t;

  // product scaled down by 2^16, saturated at 2^40, then signed
  function automatic logic signed [TERM_W-1:0] sat_term(input logic [P_W-1:0] p,
                                                        input logic neg);
    logic [P_W-17:0]   r;
    logic [TERM_W-1:0] m;
    r = p[P_W-1:16];
    if (r > TERM_LIM) m = TERM_W'(TERM_LIM);
    else m = r[TERM_W-1:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== rtl/core/mvp_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on mvp_pkg
module mvp_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  mvp_pkg::mvp_mul_req_t req,
  output logic                  done,
  output logic [mvp_pkg::P_W-1:0] prod
);
  import mvp_pkg::*;

  logic [MA_W-1:0]           a_r;
  logic [$clog2(MB_W+1)-1:0] cnt;
  logic [MA_W:0]             upper;

  assign upper = {1'b0, prod[P_W-1:MB_W]} + (prod[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= ($clog2(MB_W+1))'(MB_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(MB_W+1))'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      prod <= {{MA_W{1'b0}}, req.b};
    end else if (cnt != '0) begin
      prod <= {upper, prod[MB_W-1:1]};
    end
  end

endmodule

// ===== rtl/core/mvp_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on mvp_pkg
module mvp_div #(
  parameter int DW = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mvp_pkg::DIV_W-1:0] num,
  input  logic [DW-1:0]             den,
  output logic                      done,
  output logic [mvp_pkg::DIV_W-1:0] quot
);
  import mvp_pkg::*;

  logic [DW-1:0]              rem;
  logic [DW:0]                trial;
  logic                       ge;
  logic [DW:0]                sub;
  logic [$clog2(DIV_W+1)-1:0] cnt;

  assign trial = {rem, quot[DIV_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign sub   = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= ($clog2(DIV_W+1))'(DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(DIV_W+1))'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (cnt != '0) begin
      rem  <= ge ? sub[DW-1:0] : trial[DW-1:0];
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/motor_velocity_pid_with_safeguards_unit.sv =====
// Winch motor velocity controller. One item is worked on at a time. A force
// sample makes one pass through the shared bit-serial multiplier unless the
// filter is bypassed, and a tick makes six passes through it (one bit a cycle)
// and two through the bit-serial divider, with sequencing states between them.
// A halted tick ends before the divider and the later multiplier passes. The
// next item is taken once the current one has finished and, for a tick, its
// result sits in the output register.
// depends on mvp_pkg, mvp_mul, mvp_div
module motor_velocity_pid_with_safeguards_unit #(
  parameter int TICK_HZ        = mvp_pkg::TICK_HZ_DEF,
  parameter int HALT_TICKS     = mvp_pkg::HALT_TICKS_DEF,
  parameter int WATCHDOG_TICKS = mvp_pkg::WATCHDOG_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] encoder_position,
  input  logic signed [23:0] force_sample,
  input  logic signed [31:0] speed_setpoint,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] pwm_count,
  output logic               driver_enable,
  output logic               halted,
  output logic signed [31:0] measured_velocity,
  output logic signed [31:0] filtered_force
);
  import mvp_pkg::*;

  localparam int TICK_W = $clog2(TICK_HZ + 1);
  localparam logic [TICK_W-1:0] TICK_C = TICK_W'(TICK_HZ);
  localparam logic [15:0] HALT_C = 16'(HALT_TICKS);
  localparam logic [7:0]  WD_C   = 8'(WATCHDOG_TICKS);

  mvp_state_t state, state_next;

  // configuration
  logic signed [31:0] force_upper, force_lower, gain_prop, gain_integ, gain_deriv;
  logic [30:0]        accel_limit;
  logic [15:0]        filter_coef, pwm_period;

  // loop state
  logic signed [31:0] last_position, force_filter_state, target_register;
  logic signed [31:0] ramp_speed, previous_error;
  logic signed [47:0] error_integral;
  logic signed [17:0] pwm_level;
  logic signed [16:0] last_pwm_count;
  logic [7:0]         watchdog_count;
  logic [15:0]        halt_count;
  logic               driver_on;

  // working registers
  logic signed [47:0]      opnd;
  logic signed [31:0]      vel_r, err_r, tgt_r;
  logic [30:0]             rate_r;
  logic                    wd_fire, res_halt;
  logic signed [ACC_W-1:0] pwm_acc;

  mvp_mul_req_t    mul_req;
  logic            mul_done;
  logic [P_W-1:0]  mul_prod;
  logic            div_start, div_done;
  logic [DIV_W-1:0] div_num, div_quot;

  mvp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  mvp_div #(.DW(TICK_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (TICK_C),
    .done  (div_done),
    .quot  (div_quot)
  );

  logic               accept;
  mvp_req_t           req;
  logic signed [32:0] pos_delta, filt_delta;
  logic signed [31:0] samp_scaled;
  logic [MA_W-1:0]    opnd_mag, ei_mag;
  logic [31:0]        err_mag, gp_mag, gi_mag, gd_mag;
  logic [16:0]        pwm_mag;
  logic [17:0]        pwm_neg;
  logic [MB_W-1:0]    tick_b;

  assign accept      = in_valid && in_ready;
  assign req         = mvp_req_t'(req_type);
  assign pos_delta   = {encoder_position[31], encoder_position}
                     - {last_position[31], last_position};
  assign samp_scaled = {force_sample, 8'h00};
  assign filt_delta  = {samp_scaled[31], samp_scaled}
                     - {force_filter_state[31], force_filter_state};
  assign opnd_mag    = opnd[47] ? MA_W'(-opnd) : MA_W'(opnd);
  assign ei_mag      = error_integral[47] ? MA_W'(-error_integral) : MA_W'(error_integral);
  assign err_mag     = err_r[31] ? 32'(-err_r) : 32'(err_r);
  assign gp_mag      = gain_prop[31] ? 32'(-gain_prop) : 32'(gain_prop);
  assign gi_mag      = gain_integ[31] ? 32'(-gain_integ) : 32'(gain_integ);
  assign gd_mag      = gain_deriv[31] ? 32'(-gain_deriv) : 32'(gain_deriv);
  assign pwm_neg     = 18'(-pwm_level);
  assign pwm_mag     = pwm_level[17] ? pwm_neg[16:0] : pwm_level[16:0];
  assign tick_b      = {{(MB_W-TICK_W){1'b0}}, TICK_C};

  // safeguards
  logic signed [31:0] tgt_wd, tgt_eff;
  logic               small_tgt, force_stop, halt_req, halt_arm, halt_fire;
  logic [15:0]        hc_inc;

  assign tgt_wd     = wd_fire ? 32'sd0 : target_register;
  assign small_tgt  = (target_register >= -SMALL_VEL) && (target_register <= SMALL_VEL);
  assign force_stop = ((force_filter_state > force_upper) && (tgt_wd > 32'sd0))
                   || ((force_filter_state < force_lower) && (tgt_wd < 32'sd0));
  assign halt_req   = small_tgt || wd_fire || force_stop;
  assign tgt_eff    = force_stop ? 32'sd0 : tgt_wd;
  assign hc_inc     = (halt_count == 16'hffff) ? halt_count : halt_count + 16'd1;
  assign halt_arm   = halt_req && (last_pwm_count != 17'sd0);
  assign halt_fire  = halt_arm && (hc_inc >= HALT_C);

  // datapath helpers
  logic [P_W-1:0]     p_hi;
  logic               vel_pos_sat, vel_neg_sat;
  logic [31:0]        vel_mag;
  logic signed [31:0] vel_val;
  logic signed [32:0] filt_q, filt_sum;
  logic signed [32:0] ramp_diff, rate_s, step, ramp_sum, err_full;
  logic signed [31:0] err_sat;
  logic signed [32:0] err_delta;
  logic signed [32:0] integ_q;
  logic signed [48:0] integ_sum;
  logic signed [47:0] integ_sat;
  logic signed [47:0] diff_val;
  logic signed [17:0] pwm_sat;
  logic [15:0]        cnt_mag;
  logic signed [16:0] cnt_val;

  assign p_hi        = mul_prod;
  assign vel_pos_sat = p_hi[P_W-1:15] != '0;
  assign vel_neg_sat = (p_hi[P_W-1:16] != '0) || (p_hi[15] && (p_hi[14:0] != '0));
  assign vel_mag     = {p_hi[15:0], 16'h0000};
  always_comb begin
    if (opnd[47]) vel_val = vel_neg_sat ? 32'sh8000_0000 : -$signed(vel_mag);
    else          vel_val = vel_pos_sat ? 32'sh7fff_ffff : $signed(vel_mag);
  end

  assign filt_q   = opnd[47] ? -$signed(mul_prod[48:16]) : $signed(mul_prod[48:16]);
  assign filt_sum = {force_filter_state[31], force_filter_state} + filt_q;

  assign ramp_diff = {tgt_r[31], tgt_r} - {ramp_speed[31], ramp_speed};
  assign rate_s    = {2'b00, rate_r};
  always_comb begin
    if (ramp_diff > rate_s)       step = rate_s;
    else if (ramp_diff < -rate_s) step = -rate_s;
    else                          step = ramp_diff;
  end
  assign ramp_sum = {ramp_speed[31], ramp_speed} + step;

  assign err_full = {ramp_speed[31], ramp_speed} - {vel_r[31], vel_r};
  always_comb begin
    if (err_full > 33'sh0_7fff_ffff)       err_sat = 32'sh7fff_ffff;
    else if (err_full < -33'sh0_8000_0000) err_sat = 32'sh8000_0000;
    else                                   err_sat = err_full[31:0];
  end

  // error change, sign carried into the 48-bit operand
  assign err_delta = {err_r[31], err_r} - {previous_error[31], previous_error};

  assign integ_q   = err_r[31] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  assign integ_sum = {error_integral[47], error_integral} + 49'(integ_q);
  always_comb begin
    if (integ_sum > 49'sh0_7fff_ffff_ffff)       integ_sat = 48'sh7fff_ffff_ffff;
    else if (integ_sum < -49'sh0_8000_0000_0000) integ_sat = 48'sh8000_0000_0000;
    else                                         integ_sat = integ_sum[47:0];
  end

  assign diff_val = opnd[47] ? -$signed(mul_prod[47:0]) : $signed(mul_prod[47:0]);

  always_comb begin
    if (pwm_acc > ACC_W'(65536))       pwm_sat = 18'sd65536;
    else if (pwm_acc < -ACC_W'(65536)) pwm_sat = -18'sd65536;
    else                               pwm_sat = pwm_acc[17:0];
  end

  assign cnt_mag = mul_prod[31:16];
  assign cnt_val = pwm_level[17] ? -$signed({1'b0, cnt_mag}) : $signed({1'b0, cnt_mag});

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      force_upper <= 32'sh7fff_ffff;
      force_lower <= 32'sh8000_0000;
      accel_limit <= '0;
      gain_prop   <= '0;
      gain_integ  <= '0;
      gain_deriv  <= '0;
      filter_coef <= '0;
      pwm_period  <= 16'd4800;
    end else if (cfg_we) begin
      unique case (mvp_reg_t'(cfg_index))
        REG_FORCE_UP:  force_upper <= cfg_data;
        REG_FORCE_LO:  force_lower <= cfg_data;
        REG_ACCEL:     accel_limit <= cfg_data[30:0];
        REG_GAIN_P:    gain_prop   <= cfg_data;
        REG_GAIN_I:    gain_integ  <= cfg_data;
        REG_GAIN_D:    gain_deriv  <= cfg_data;
        REG_FILT_COEF: filter_coef <= cfg_data[15:0];
        REG_PWM_PER:   pwm_period  <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (req)
            REQ_TICK:  state_next = ST_VEL_GO;
            REQ_FORCE: state_next = (filter_coef != '0) ? ST_FILT_GO : ST_IDLE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILT_GO:    state_next = ST_FILT_WAIT;
      ST_FILT_WAIT:  if (mul_done) state_next = ST_IDLE;
      ST_VEL_GO:     state_next = ST_VEL_WAIT;
      ST_VEL_WAIT:   if (mul_done) state_next = ST_HALT;
      ST_HALT:       state_next = halt_fire ? ST_OUT : ST_RATE_WAIT;
      ST_RATE_WAIT:  if (div_done) state_next = ST_RAMP;
      ST_RAMP:       state_next = ST_ERR;
      ST_ERR:        state_next = ST_PROP;
      ST_PROP:       state_next = ST_PROP_WAIT;
      ST_PROP_WAIT:  if (mul_done) state_next = ST_DMUL;
      ST_DMUL:       state_next = ST_DMUL_WAIT;
      ST_DMUL_WAIT:  if (mul_done) state_next = ST_INTEG;
      ST_INTEG:      state_next = ST_INTEG_WAIT;
      ST_INTEG_WAIT: if (mul_done) state_next = ST_DERIV;
      ST_DERIV:      state_next = ST_DERIV_WAIT;
      ST_DERIV_WAIT: if (mul_done) state_next = ST_CLAMP;
      ST_CLAMP:      state_next = ST_COUNT;
      ST_COUNT:      state_next = ST_COUNT_WAIT;
      ST_COUNT_WAIT: if (mul_done) state_next = ST_OUT;
      ST_OUT:        if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_req   = '0;
    div_start = 1'b0;
    div_num   = '0;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_FILT_GO: mul_req = '{1'b1, opnd_mag, MB_W'(17'h1_0000 - {1'b0, filter_coef})};
      ST_VEL_GO:  mul_req = '{1'b1, opnd_mag, tick_b};
      ST_HALT: begin
        div_start = !halt_fire;
        div_num   = {1'b0, accel_limit};
      end
      ST_PROP: begin
        mul_req   = '{1'b1, {16'h0000, err_mag}, gp_mag};
        div_start = 1'b1;
        div_num   = err_mag;
      end
      ST_DMUL:  mul_req = '{1'b1, opnd_mag, tick_b};
      ST_INTEG: mul_req = '{1'b1, ei_mag, gi_mag};
      ST_DERIV: mul_req = '{1'b1, opnd_mag, gd_mag};
      ST_COUNT: mul_req = '{1'b1, {31'h0, pwm_mag}, {16'h0000, pwm_period}};
      default:  ;
    endcase
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_position      <= '0;
      force_filter_state <= '0;
      target_register    <= '0;
      watchdog_count     <= '0;
      halt_count         <= '0;
      ramp_speed         <= '0;
      previous_error     <= '0;
      error_integral     <= '0;
      pwm_level          <= '0;
      last_pwm_count     <= '0;
      driver_on          <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority case (req)
              REQ_TICK: begin
                last_position <= encoder_position;
                if (watchdog_count != 8'hff) watchdog_count <= watchdog_count + 8'd1;
              end
              REQ_FORCE: if (filter_coef == '0) force_filter_state <= samp_scaled;
              REQ_CMD: begin
                target_register <= speed_setpoint;
                watchdog_count  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_FILT_WAIT: if (mul_done) force_filter_state <= filt_sum[31:0];
        ST_HALT: begin
          halt_count <= halt_arm ? hc_inc : 16'd0;
          if (halt_fire) begin
            driver_on      <= 1'b0;
            pwm_level      <= '0;
            ramp_speed     <= '0;
            error_integral <= '0;
          end
        end
        ST_RAMP:      ramp_speed     <= ramp_sum[31:0];
        ST_PROP:      previous_error <= err_r;
        ST_PROP_WAIT: if (mul_done) error_integral <= integ_sat;
        ST_CLAMP:     pwm_level <= pwm_sat;
        ST_COUNT_WAIT: begin
          if (mul_done) begin
            last_pwm_count <= cnt_val;
            driver_on      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          wd_fire <= watchdog_count > WD_C;
          if (req == REQ_TICK) opnd <= 48'(pos_delta);
          else                 opnd <= 48'(filt_delta);
        end
      end
      ST_VEL_WAIT: if (mul_done) vel_r <= vel_val;
      ST_HALT: begin
        tgt_r    <= tgt_eff;
        res_halt <= halt_fire;
      end
      ST_RATE_WAIT: if (div_done) rate_r <= div_quot[30:0];
      ST_ERR:       err_r <= err_sat;
      ST_PROP: begin
        opnd    <= 48'(err_delta);
        pwm_acc <= ACC_W'(pwm_level);
      end
      ST_PROP_WAIT:
        if (mul_done) pwm_acc <= pwm_acc + ACC_W'(sat_term(mul_prod, err_r[31] ^ gain_prop[31]));
      ST_DMUL_WAIT: if (mul_done) opnd <= diff_val;
      ST_INTEG_WAIT:
        if (mul_done)
          pwm_acc <= pwm_acc + ACC_W'(sat_term(mul_prod, error_integral[47] ^ gain_integ[31]));
      ST_DERIV_WAIT:
        if (mul_done) pwm_acc <= pwm_acc + ACC_W'(sat_term(mul_prod, opnd[47] ^ gain_deriv[31]));
      default: ;
    endcase
  end

  // output register, one beat per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      pwm_count         <= res_halt ? 17'sd0 : last_pwm_count;
      driver_enable     <= driver_on;
      halted            <= res_halt;
      measured_velocity <= vel_r;
      filtered_force    <= force_filter_state;
    end
  end

endmodule

// ===== rtl/core/mvp_checker.sv =====
// port-level checks for the velocity controller, bound to the top level
// depends on motor_velocity_pid_with_safeguards_unit
module mvp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] pwm_count,
  input logic               driver_enable,
  input logic               halted
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_count) && $stable(halted))
    else $error("result beat dropped or changed while stalled");

  a_halt_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !driver_enable && pwm_count == 17'sd0)
    else $error("halted beat still drives the bridge");

  a_enable_xor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> driver_enable != halted)
    else $error("driver enable and halt flag disagree");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn before it was taken");

endmodule

bind motor_velocity_pid_with_safeguards_unit mvp_checker u_mvp_checker (.*);
